// ----- sv/mcfb_pkg.sv -----
`default_nettype none

package mcfb_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int BIDX_W      = $clog2(FRAME_BYTES);
  localparam logic [BIDX_W-1:0] LAST_IDX = BIDX_W'(FRAME_BYTES - 1);

  // Frame queue between the front and back parts
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Configuration register widths
  localparam int LIM_W  = 15;
  localparam int GAIN_W = 24;
  localparam int CFG_W  = 24;
  localparam int ADDR_W = 3;
  localparam int PROD_W = LIM_W + GAIN_W;

  // Frame constants
  localparam logic [7:0] CMD_MOTION   = 8'h64;
  localparam logic [7:0] CMD_GET_MODE = 8'h74;
  localparam logic [7:0] CMD_SET_MODE = 8'hA0;
  localparam logic [7:0] GET_ID_HEAD  = 8'hC8;
  localparam logic [7:0] SET_ID_B0    = 8'hAA;
  localparam logic [7:0] SET_ID_B1    = 8'h55;
  localparam logic [7:0] SET_ID_B2    = 8'h53;
  localparam logic [7:0] BRAKE_ON     = 8'hFF;
  localparam logic [7:0] CRC_POLY     = 8'h8C;

  localparam logic [PROD_W:0]  ROUND_HALF = (PROD_W + 1)'(32768);
  localparam logic [LIM_W-1:0] CODE_MAX   = LIM_W'(32767);

  // Reset values of the configuration registers
  localparam logic [LIM_W-1:0]  RST_VEL_LIMIT    = LIM_W'(330);
  localparam logic [LIM_W-1:0]  RST_CUR_LIMIT    = LIM_W'(8192);
  localparam logic [GAIN_W-1:0] RST_CURRENT_GAIN = GAIN_W'(262136);
  localparam logic [LIM_W-1:0]  RST_ANG_LIMIT    = LIM_W'(360);
  localparam logic [GAIN_W-1:0] RST_ANGLE_GAIN   = GAIN_W'(5965050);

  typedef enum logic [2:0] {
    REQ_VELOCITY = 3'd0,
    REQ_CURRENT  = 3'd1,
    REQ_POSITION = 3'd2,
    REQ_BRAKE    = 3'd3,
    REQ_GET_MODE = 3'd4,
    REQ_SET_MODE = 3'd5,
    REQ_SET_ID   = 3'd6,
    REQ_GET_ID   = 3'd7
  } req_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_VEL_LIMIT    = 3'd0,
    REG_CUR_LIMIT    = 3'd1,
    REG_CURRENT_GAIN = 3'd2,
    REG_ANG_LIMIT    = 3'd3,
    REG_ANGLE_GAIN   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LIM_W-1:0]  vel_limit;
    logic [LIM_W-1:0]  cur_limit;
    logic [GAIN_W-1:0] current_gain;
    logic [LIM_W-1:0]  ang_limit;
    logic [GAIN_W-1:0] angle_gain;
  } cfg_t;

  // One complete frame; byte 9 is replaced by the CRC when crc_en is set.
  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] body;
    logic                        crc_en;
  } desc_t;

  // One byte of CRC-8/MAXIM (reflected, polynomial 0x8C).
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mcfb_front.sv -----
`default_nettype none

module mcfb_front
  import mcfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_motor_id,
  input  logic [15:0] in_velocity,
  input  logic [7:0]  in_accel,
  input  logic [15:0] in_current,
  input  logic [15:0] in_angle,
  input  logic [7:0]  in_mode,
  output logic        q_push,
  output desc_t       q_data,
  input  logic        q_full
);

  // Stage A: clamp and frame template
  logic              a_v_r;
  desc_t             a_tmpl_r;
  logic              a_coded_r;
  logic              a_scale_r;
  logic              a_neg_r;
  logic [LIM_W-1:0]  a_mag_r;
  logic [GAIN_W-1:0] a_gain_r;

  // Stage B: product registered
  logic              b_v_r;
  desc_t             b_tmpl_r;
  logic              b_coded_r;
  logic              b_scale_r;
  logic              b_neg_r;
  logic [LIM_W-1:0]  b_mag_r;
  logic [PROD_W-1:0] b_prod_r;

  logic a_adv, b_adv, accept;

  req_t               req;
  logic signed [15:0] val;
  logic [LIM_W-1:0]   lim;
  logic [GAIN_W-1:0]  gain;
  logic signed [16:0] vs, ls;
  logic [15:0]        absv;
  desc_t              tmpl;
  logic               coded, scale, neg;
  logic [LIM_W-1:0]   mag;

  assign b_adv   = !b_v_r || !q_full;
  assign a_adv   = !a_v_r || b_adv;
  assign in_full = !a_adv;
  assign accept  = in_push && a_adv;

  always_comb begin
    req   = req_t'(in_req_type);
    val   = in_velocity;
    lim   = cfg.vel_limit;
    gain  = cfg.current_gain;
    coded = 1'b0;
    scale = 1'b0;
    tmpl  = '0;
    tmpl.body[0] = in_motor_id;
    tmpl.body[1] = CMD_MOTION;
    tmpl.crc_en  = 1'b1;
    unique case (req)
      REQ_VELOCITY: begin
        coded = 1'b1;
        tmpl.body[6] = in_accel;
      end
      REQ_CURRENT: begin
        coded = 1'b1;
        scale = 1'b1;
        val   = in_current;
        lim   = cfg.cur_limit;
      end
      REQ_POSITION: begin
        coded = 1'b1;
        scale = 1'b1;
        val   = in_angle;
        lim   = cfg.ang_limit;
        gain  = cfg.angle_gain;
      end
      REQ_BRAKE: begin
        tmpl.body[7] = BRAKE_ON;
      end
      REQ_GET_MODE: begin
        tmpl.body[1] = CMD_GET_MODE;
      end
      REQ_SET_MODE: begin
        tmpl.body[1] = CMD_SET_MODE;
        tmpl.body[9] = in_mode;
        tmpl.crc_en  = 1'b0;
      end
      REQ_SET_ID: begin
        tmpl.body[0] = SET_ID_B0;
        tmpl.body[1] = SET_ID_B1;
        tmpl.body[2] = SET_ID_B2;
        tmpl.body[3] = in_motor_id;
        tmpl.crc_en  = 1'b0;
      end
      REQ_GET_ID: begin
        tmpl.body[0] = GET_ID_HEAD;
      end
      default: begin
        tmpl.body[0] = GET_ID_HEAD;
      end
    endcase

    // Symmetric clamp, then split into sign and 15-bit magnitude.
    vs   = {val[15], val};
    ls   = signed'({2'b00, lim});
    absv = val[15] ? (16'd0 - val) : val;
    if (vs > ls) begin
      mag = lim;
      neg = 1'b0;
    end else if (vs < -ls) begin
      mag = lim;
      neg = 1'b1;
    end else begin
      mag = absv[LIM_W-1:0];
      neg = val[15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_adv) begin
        a_v_r <= accept;
      end
      if (b_adv) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_tmpl_r  <= tmpl;
      a_coded_r <= coded;
      a_scale_r <= scale;
      a_neg_r   <= neg;
      a_mag_r   <= mag;
      a_gain_r  <= gain;
    end
    if (b_adv && a_v_r) begin
      b_tmpl_r  <= a_tmpl_r;
      b_coded_r <= a_coded_r;
      b_scale_r <= a_scale_r;
      b_neg_r   <= a_neg_r;
      b_mag_r   <= a_mag_r;
      b_prod_r  <= PROD_W'(a_mag_r) * PROD_W'(a_gain_r);
    end
  end

  // Round the Q16 product, saturate, negate and place in bytes 2 and 3.
  logic [PROD_W:0]    rnd;
  logic [GAIN_W-1:0]  rsh;
  logic [LIM_W-1:0]   sat, mag_code;
  logic [15:0]        code;

  always_comb begin
    rnd      = (PROD_W + 1)'(b_prod_r) + ROUND_HALF;
    rsh      = rnd[PROD_W -: GAIN_W];
    sat      = (|rsh[GAIN_W-1:LIM_W]) ? CODE_MAX : rsh[LIM_W-1:0];
    mag_code = b_scale_r ? sat : b_mag_r;
    code     = b_neg_r ? (16'd0 - {1'b0, mag_code}) : {1'b0, mag_code};
    q_data   = b_tmpl_r;
    if (b_coded_r) begin
      q_data.body[2] = code[15:8];
      q_data.body[3] = code[7:0];
    end
  end

  assign q_push = b_v_r && !q_full;

endmodule

`default_nettype wire

// ----- sv/mcfb_fifo.sv -----
`default_nettype none

module mcfb_fifo
  import mcfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  output logic  full,
  input  logic  pop,
  output desc_t rdata,
  output logic  empty
);

  desc_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rptr_r];

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= inc(rptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mcfb_back.sv -----
`default_nettype none

module mcfb_back
  import mcfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  desc_t             q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_frame_byte,
  output logic [BIDX_W-1:0] out_byte_index,
  output logic              out_last
);

  logic              ov_r;
  logic [BIDX_W-1:0] idx_r;
  logic [7:0]        crc_r;
  logic [7:0]        byte_r;
  logic [BIDX_W-1:0] oidx_r;
  logic              olast_r;

  logic       load, is_last;
  logic [7:0] crc_in, cur;

  assign load    = !q_empty && (!ov_r || out_pop);
  assign is_last = (idx_r == LAST_IDX);
  assign crc_in  = (idx_r == '0) ? 8'h00 : crc_r;
  assign cur     = (is_last && q_data.crc_en) ? crc_in : q_data.body[idx_r];
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= is_last ? '0 : idx_r + 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      crc_r   <= crc8_step(crc_in, cur);
      byte_r  <= cur;
      oidx_r  <= idx_r;
      olast_r <= is_last;
    end
  end

  assign out_empty      = !ov_r;
  assign out_frame_byte = byte_r;
  assign out_byte_index = oidx_r;
  assign out_last       = olast_r;

endmodule

`default_nettype wire

// ----- sv/motor_command_frame_builder.sv -----
// Channel   Direction  Handshake            Payload
// input     in         in_push / in_full    req_type, motor_id, velocity, accel,
//                                           current, angle, mode
// result    out        out_empty / out_pop  frame_byte, byte_index, last
// config    in         cfg_we               cfg_addr, cfg_wdata
//
// Each request yields ten result transactions, one a cycle while out_pop takes them;
// the byte serialiser in the back part sets the sustained request rate. An accepted
// request passes stage A and stage B before it is pushed into the queue, and the
// back part then registers its first byte. Reset is synchronous and active low; it
// empties all stages and loads the configuration registers with their reset values.
// Either side may stall independently; stalls propagate back through the queue.
`default_nettype none

module motor_command_frame_builder
  import mcfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_push,
  output logic              in_full,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_motor_id,
  input  logic [15:0]       in_velocity,
  input  logic [7:0]        in_accel,
  input  logic [15:0]       in_current,
  input  logic [15:0]       in_angle,
  input  logic [7:0]        in_mode,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_frame_byte,
  output logic [BIDX_W-1:0] out_byte_index,
  output logic              out_last
);

  // Configuration registers. Writes to unused indexes are simply dropped.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vel_limit    <= RST_VEL_LIMIT;
      cfg_r.cur_limit    <= RST_CUR_LIMIT;
      cfg_r.current_gain <= RST_CURRENT_GAIN;
      cfg_r.ang_limit    <= RST_ANG_LIMIT;
      cfg_r.angle_gain   <= RST_ANGLE_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_VEL_LIMIT:    cfg_r.vel_limit    <= cfg_wdata[LIM_W-1:0];
        REG_CUR_LIMIT:    cfg_r.cur_limit    <= cfg_wdata[LIM_W-1:0];
        REG_CURRENT_GAIN: cfg_r.current_gain <= cfg_wdata[GAIN_W-1:0];
        REG_ANG_LIMIT:    cfg_r.ang_limit    <= cfg_wdata[LIM_W-1:0];
        REG_ANGLE_GAIN:   cfg_r.angle_gain   <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front part clamps, scales and assembles each frame, the queue holds
  // finished frames, and the back part streams them out byte by byte while
  // folding each byte into the running CRC.
  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_wdata, q_rdata;

  mcfb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_req_type (in_req_type),
    .in_motor_id (in_motor_id),
    .in_velocity (in_velocity),
    .in_accel    (in_accel),
    .in_current  (in_current),
    .in_angle    (in_angle),
    .in_mode     (in_mode),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  mcfb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mcfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

`ifndef SYNTH
  // A frame is never split: after a non-final byte is taken, the next byte of
  // the same frame is shown straight away with the following index.
  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last) |=>
      (!out_empty && out_byte_index == BIDX_W'($past(out_byte_index) + 1'b1)))
    else $error("frame bytes not contiguous");

  // The last flag marks the final byte position and no other.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last == (out_byte_index == LAST_IDX)))
    else $error("last flag and byte index disagree");

  // The frame queue cannot be full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("frame queue full and empty together");
`endif

endmodule

`default_nettype wire
